// ===== hdl/pfba_pkg.sv =====
// Shared constants and types of the page frame bitmap allocator.
// No dependencies.
`default_nettype none
package pfba_pkg;
    localparam int NumRegions = 2;
    localparam int CfgRegions = 2;
    localparam int MaxPages   = 4096;
    localparam int StackDepth = 256;
    localparam int PageBits   = 12;
    localparam int FrameW     = 36;
    localparam int AddrW      = 48;
    localparam int PagesW     = 13;
    localparam int PageIdxW   = $clog2(MaxPages);
    localparam int LiveRegions = (NumRegions < CfgRegions) ? NumRegions : CfgRegions;
    localparam int RegW       = (LiveRegions > 1) ? $clog2(LiveRegions) : 1;
    localparam int BmAddrW    = RegW + PageIdxW;
    localparam int BmDepth    = LiveRegions * MaxPages;
    localparam int StkW       = $clog2(StackDepth + 1);
    localparam int StkIdxW    = (StackDepth > 1) ? $clog2(StackDepth) : 1;
    localparam int CfgIdxW    = 3;
    localparam int InDataW    = 56;
    localparam int OutDataW   = 48;
    localparam int OutUserW   = 2;

    localparam logic [CfgIdxW-1:0] CFG_REGION_COUNT = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_R0_FIRST     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_R0_PAGES     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_R1_FIRST     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_R1_PAGES     = 3'd4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_POP,
        ST_QUERY,
        ST_DONE
    } state_t;

    // Command from the sequencer to the bitmap memory.
    typedef struct packed {
        logic               wr;
        logic [BmAddrW-1:0] addr;
    } bm_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/pfba_bitmap_ram.sv =====
// Used-page bitmap memory with a sweep that clears it after reset.
// Depends on pfba_pkg.
`default_nettype none
module pfba_bitmap_ram
    import pfba_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire bm_cmd_t cmd,
    output logic         rd_bit,
    output logic         clear_done
);
    logic mem [BmDepth];
    logic [BmAddrW:0] clr_reg;
    logic [BmAddrW:0] clr_next;

    assign clear_done = (clr_reg == (BmAddrW+1)'(BmDepth));
    assign clr_next   = clear_done ? clr_reg : clr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else
            clr_reg <= clr_next;
    end

    // Apart from the clear sweep, writes only set a bit; reads see the value before the write.
    always_ff @(posedge clk)
    begin
        if (!clear_done)
            mem[clr_reg[BmAddrW-1:0]] <= 1'b0;
        else if (cmd.wr)
            mem[cmd.addr] <= 1'b1;
        rd_bit <= mem[cmd.addr];
    end
endmodule
`default_nettype wire

// ===== hdl/pfba_stack_ram.sv =====
// Free frame stack storage, one write and one registered read port.
// Depends on pfba_pkg.
`default_nettype none
module pfba_stack_ram
    import pfba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               wr,
    input  wire logic [StkIdxW-1:0] waddr,
    input  wire logic [FrameW-1:0]  wdata,
    input  wire logic [StkIdxW-1:0] raddr,
    output logic      [FrameW-1:0]  rdata
);
    logic [FrameW-1:0] mem [StackDepth];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/page_frame_bitmap_allocator.sv =====
// Allocate: with frames on the stack the beat goes to the pop state, which takes the top,
// then to the done state, which loads the output register; an empty stack first runs a
// refill scan (per page a bitmap read, then mark and push, plus a step to each next region
// and one to finish). Query: query state, then done state. A new beat is taken only in the
// idle state; a held result stalls the next one in the done state. After reset the bitmap
// memory is cleared, one entry a cycle, all NUM_REGIONS*MAX_PAGES = 8192 entries, with no
// request taken; reset is asynchronous and active low. Top level: sequencer, registers and
// output stage. Depends on pfba_pkg, pfba_bitmap_ram and pfba_stack_ram.
`default_nettype none
module page_frame_bitmap_allocator
    import pfba_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [InDataW-1:0]  s_axis_tdata,  // address[47:0], zeros
    input  wire logic                s_axis_tuser,  // func
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [OutDataW-1:0] m_axis_tdata,  // page_address[47:0]
    output logic      [OutUserW-1:0] m_axis_tuser,  // ok, in_use
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [FrameW-1:0]   cfg_data
);
    state_t state_reg, state_next;
    logic [1:0]          rcount_reg;
    logic [FrameW-1:0]   first_reg [CfgRegions];
    logic [PagesW-1:0]   pages_reg [CfgRegions];
    logic [StkW-1:0]     cnt_reg, cnt_next;
    logic [RegW-1:0]     sr_reg, sr_next;
    logic [PageIdxW:0]   sj_reg, sj_next;
    logic                qhit_reg, qhit_next;
    logic [RegW-1:0]     qreg_next;
    logic [PageIdxW-1:0] qidx_next;
    logic                ovalid_reg;
    logic [AddrW-1:0]    oaddr_reg, oaddr_next;
    logic                ook_reg, ook_next, ouse_reg, ouse_next;
    logic [AddrW-1:0]    out_addr_reg;
    logic                out_ok_reg, out_use_reg;
    logic                load_out;
    bm_cmd_t             bm_cmd;
    logic                bm_bit, clear_done;
    logic                stk_wr;
    logic [FrameW-1:0]   stk_wdata, stk_rdata;
    logic [RegW:0]       nreg;
    logic [PageIdxW:0]   np_cur;
    logic                scan_page_ok, scan_reg_ok, scan_last;
    logic [PageIdxW:0]   np_q [LiveRegions];

    pfba_bitmap_ram u_bitmap (
        .clk(clk), .rst_n(rst_n), .cmd(bm_cmd), .rd_bit(bm_bit), .clear_done(clear_done)
    );
    pfba_stack_ram u_stack (
        .clk(clk), .wr(stk_wr), .waddr(cnt_reg[StkIdxW-1:0]), .wdata(stk_wdata),
        .raddr(StkIdxW'(cnt_reg - 1'b1)), .rdata(stk_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && clear_done;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_addr_reg;
    assign m_axis_tuser  = {out_use_reg, out_ok_reg};

    assign nreg = (rcount_reg > 2'(LiveRegions)) ? (RegW+1)'(LiveRegions)
                                                 : (RegW+1)'(rcount_reg);
    always_comb
    begin
        for (int r = 0; r < LiveRegions; r++)
            np_q[r] = (pages_reg[r] > PagesW'(MaxPages)) ? (PageIdxW+1)'(MaxPages)
                                                        : (PageIdxW+1)'(pages_reg[r]);
    end
    assign np_cur       = np_q[sr_reg];
    assign scan_reg_ok  = ({1'b0, sr_reg} < nreg);
    assign scan_page_ok = scan_reg_ok && (sj_reg < np_cur)
                          && (cnt_reg < StkW'(StackDepth));
    // The last region has been walked to its end.
    assign scan_last    = (sj_reg >= np_cur) && (sr_reg == RegW'(LiveRegions - 1));
    assign stk_wdata    = first_reg[sr_reg] + FrameW'(sj_reg);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcount_reg <= '0;
            for (int r = 0; r < CfgRegions; r++)
            begin
                first_reg[r] <= '0;
                pages_reg[r] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REGION_COUNT: rcount_reg <= cfg_data[1:0];
                CFG_R0_FIRST:     first_reg[0] <= cfg_data;
                CFG_R0_PAGES:     pages_reg[0] <= cfg_data[PagesW-1:0];
                CFG_R1_FIRST:     if (NumRegions > 1) first_reg[1] <= cfg_data;
                CFG_R1_PAGES:     if (NumRegions > 1) pages_reg[1] <= cfg_data[PagesW-1:0];
                default: ;
            endcase
        end
    end

    // Query region match, registered on the input beat.
    always_comb
    begin
        logic [FrameW-1:0] fr;
        logic [FrameW:0]   dif;
        fr = s_axis_tdata[AddrW-1:PageBits];
        qhit_next = 1'b0;
        qreg_next = '0;
        qidx_next = '0;
        for (int r = LiveRegions - 1; r >= 0; r--)
        begin
            dif = {1'b0, fr} - {1'b0, first_reg[r]};
            if (((RegW+1)'(r) < nreg) && !dif[FrameW]
                && (dif < (FrameW+1)'(np_q[r])))
            begin
                qhit_next = 1'b1;
                qreg_next = RegW'(r);
                qidx_next = dif[PageIdxW-1:0];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                    state_next = (s_axis_tuser == FUNC_QUERY) ? ST_QUERY
                               : (cnt_reg == '0) ? ST_SCAN : ST_POP;
            ST_SCAN:
                if (scan_page_ok)
                    state_next = ST_SCAN_WAIT;
                else if (!scan_reg_ok || cnt_reg == StkW'(StackDepth) || scan_last)
                    state_next = (cnt_reg == '0) ? ST_DONE : ST_POP;
            ST_SCAN_WAIT: state_next = ST_SCAN;
            ST_POP:       state_next = ST_DONE;
            ST_QUERY:     state_next = ST_DONE;
            ST_DONE:      if (!ovalid_reg || m_axis_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb
    begin
        sr_next    = sr_reg;
        sj_next    = sj_reg;
        cnt_next   = cnt_reg;
        stk_wr     = 1'b0;
        bm_cmd.wr   = 1'b0;
        bm_cmd.addr = {sr_reg, sj_reg[PageIdxW-1:0]};
        oaddr_next = oaddr_reg;
        ook_next   = ook_reg;
        ouse_next  = ouse_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sr_next = '0;
                sj_next = '0;
                bm_cmd.addr = {qreg_next, qidx_next};
                oaddr_next = '0;
                ook_next   = 1'b0;
                ouse_next  = 1'b0;
            end
            ST_SCAN:
                if (!scan_page_ok && scan_reg_ok && sj_reg >= np_cur)
                begin
                    sj_next = '0;
                    sr_next = sr_reg + 1'b1;
                    if (sr_reg == RegW'(LiveRegions - 1))
                        sr_next = sr_reg;
                end
            ST_SCAN_WAIT:
            begin
                if (!bm_bit)
                begin
                    bm_cmd.wr = 1'b1;
                    stk_wr    = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                sj_next = sj_reg + 1'b1;
            end
            ST_POP:
            begin
                cnt_next   = cnt_reg - 1'b1;
                oaddr_next = {stk_rdata, PageBits'(0)};
                ook_next   = 1'b1;
            end
            ST_QUERY:
            begin
                ook_next  = qhit_reg;
                ouse_next = qhit_reg & bm_bit;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                    load_out = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
        sj_reg <= sj_next;
        if (state_reg == ST_IDLE)
            qhit_reg <= qhit_next;
        oaddr_reg <= oaddr_next;
        ook_reg   <= ook_next;
        ouse_reg  <= ouse_next;
        // The output beat keeps its own copy so the next request can proceed.
        if (load_out)
        begin
            out_addr_reg <= oaddr_reg;
            out_ok_reg   <= ook_reg;
            out_use_reg  <= ouse_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= StkW'(StackDepth))
        else $error("stack count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |-> cnt_reg != '0)
        else $error("pop from empty stack");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        stk_wr |-> cnt_reg < StkW'(StackDepth))
        else $error("push into full stack");
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !s_axis_tready)
        else $error("request taken during clear");
    a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUERY && !qhit_reg) |=> !ouse_reg)
        else $error("in_use on a missed query");
`endif
endmodule
`default_nettype wire

// ===== dv/page_frame_bitmap_allocator_test.sv =====
// Self-checking testbench for page_frame_bitmap_allocator: stream driver, result
// monitor and a cycle-free predictor of the bitmap, free-frame stack and region map.
// Depends on pfba_pkg and the RTL under hdl/.
`default_nettype none
module page_frame_bitmap_allocator_test;
    import pfba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 100000;
    localparam int HoldCycles    = 400;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic             func;
        logic [AddrW-1:0] addr;
    } page_req_t;

    typedef struct {
        logic [AddrW-1:0] page_addr;
        logic             ok;
        logic             in_use;
    } grant_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [OutUserW-1:0] m_axis_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [FrameW-1:0]   cfg_data = '0;

    // Shadow registers and allocator state.
    logic [1:0]        region_cnt = '0;
    logic [FrameW-1:0] cfg_first [CfgRegions];
    logic [PagesW-1:0] cfg_pages [CfgRegions];
    bit                used_map [NumRegions][MaxPages];
    logic [FrameW-1:0] frame_stack [StackDepth];
    int                stack_fill = 0;

    page_req_t req_q[$];
    grant_t    grant_q[$];
    page_req_t cur_req;
    int        errors = 0;
    bit        idle_en = 1'b0;
    bit        hold_kick = 1'b0;
    bit        hold_seen = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        quiet_cycles = 0;

    page_frame_bitmap_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int live_regions();
        int n;
        n = region_cnt;
        if (n > NumRegions) n = NumRegions;
        if (n > CfgRegions) n = CfgRegions;
        return n;
    endfunction

    function automatic int live_pages(int r);
        return (cfg_pages[r] > MaxPages) ? MaxPages : int'(cfg_pages[r]);
    endfunction

    // Scan regions in order, pages upward, claiming clear pages until the stack is full.
    function automatic void refill_stack();
        int nreg;
        int np;
        nreg = live_regions();
        for (int r = 0; r < nreg; r++)
        begin
            np = live_pages(r);
            for (int j = 0; j < np; j++)
            begin
                if (stack_fill >= StackDepth)
                    return;
                if (!used_map[r][j])
                begin
                    used_map[r][j] = 1'b1;
                    frame_stack[stack_fill] = cfg_first[r] + FrameW'(j);
                    stack_fill++;
                end
            end
        end
    endfunction

    function automatic grant_t predict_grant(page_req_t req);
        grant_t g;
        longint unsigned frame;
        longint unsigned lo;
        int nreg;
        g = '{page_addr: '0, ok: 1'b0, in_use: 1'b0};
        if (req.func == FUNC_ALLOC)
        begin
            if (stack_fill == 0)
                refill_stack();
            if (stack_fill != 0)
            begin
                stack_fill--;
                g.page_addr = {frame_stack[stack_fill], {PageBits{1'b0}}};
                g.ok = 1'b1;
            end
        end
        else
        begin
            frame = req.addr >> PageBits;
            nreg = live_regions();
            for (int r = 0; r < nreg; r++)
            begin
                lo = cfg_first[r];
                if (frame >= lo && frame < lo + live_pages(r))
                begin
                    g.ok = 1'b1;
                    g.in_use = used_map[r][frame - lo];
                    break;
                end
            end
        end
        return g;
    endfunction

    // Queries aimed into a live region are most common; some allocations, some stray addresses.
    function automatic page_req_t random_req();
        page_req_t req;
        int sel;
        int r;
        logic [FrameW-1:0] frame;
        sel = $urandom_range(0, 99);
        req.addr = {16'($urandom), 32'($urandom)};
        req.func = (sel < 40) ? FUNC_ALLOC : FUNC_QUERY;
        if (sel >= 40 && sel < 85 && live_regions() > 0)
        begin
            r = $urandom_range(0, live_regions() - 1);
            if (live_pages(r) > 0)
            begin
                frame = cfg_first[r] + FrameW'($urandom_range(0, live_pages(r) - 1));
                req.addr = {frame, 12'($urandom)};
            end
        end
        return req;
    endfunction

    // Driver: one decision per edge, so tvalid never gets two updates in a step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                grant_q.push_back(predict_grant(cur_req));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                cur_req = req_q.pop_front();
                s_axis_tdata <= InDataW'(cur_req.addr);
                s_axis_tuser <= cur_req.func;
                s_axis_tvalid <= 1'b1;
                send_gap <= draw_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor and receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        grant_t exp_g;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grant_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    exp_g = grant_q.pop_front();
                    if (m_axis_tdata !== exp_g.page_addr)
                    begin
                        $error("page_address: expected %h, got %h", exp_g.page_addr,
                               m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== exp_g.ok)
                    begin
                        $error("ok: expected %b, got %b", exp_g.ok, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== exp_g.in_use)
                    begin
                        $error("in_use: expected %b, got %b", exp_g.in_use,
                               m_axis_tuser[1]);
                        errors++;
                    end
                end
            end
            if (hold_kick != hold_seen)
            begin
                hold_seen <= hold_kick;
                recv_gap <= HoldCycles;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap <= draw_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [FrameW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_REGION_COUNT: region_cnt = value[1:0];
            CFG_R0_FIRST:     cfg_first[0] = value;
            CFG_R0_PAGES:     cfg_pages[0] = value[PagesW-1:0];
            CFG_R1_FIRST:     if (LiveRegions > 1) cfg_first[1] = value;
            CFG_R1_PAGES:     if (LiveRegions > 1) cfg_pages[1] = value[PagesW-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_regions(logic [1:0] cnt, logic [FrameW-1:0] f0, logic [12:0] p0,
                               logic [FrameW-1:0] f1, logic [12:0] p1);
        write_reg(CFG_REGION_COUNT, FrameW'(cnt));
        write_reg(CFG_R0_FIRST, f0);
        write_reg(CFG_R0_PAGES, FrameW'(p0));
        write_reg(CFG_R1_FIRST, f1);
        write_reg(CFG_R1_PAGES, FrameW'(p1));
    endtask

    task automatic push_req(logic func, logic [AddrW-1:0] addr);
        page_req_t req;
        req.func = func;
        req.addr = addr;
        req_q.push_back(req);
    endtask

    // Sampled at the falling edge, away from the driver's and monitor's updates.
    task automatic drain();
        do
            @(negedge clk);
        while (req_q.size() > 0 || s_axis_tvalid || grant_q.size() > 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_random(int n, bit idle, bit hold);
        idle_en = idle;
        for (int i = 0; i < n; i++)
            req_q.push_back(random_req());
        if (hold)
        begin
            @(posedge clk);
            hold_kick <= ~hold_kick;
        end
        drain();
    endtask

    initial
    begin
        cfg_first = '{default: '0};
        cfg_pages = '{default: '0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Oversized page count saturates; region 1 sits at the top of the frame space.
        set_regions(2'd2, '0, 13'h1FFF, 36'hF_FFFF_FFFE, 13'd4);
        write_reg(CFG_UNUSED, FrameW'($urandom));
        push_req(FUNC_QUERY, 48'h0);
        push_req(FUNC_QUERY, 48'hFFFF_FFFF_FFFF);
        push_req(FUNC_ALLOC, 48'hFFFF_FFFF_FFFF);
        push_req(FUNC_ALLOC, 48'h0);
        push_req(FUNC_ALLOC, 48'h0);
        push_req(FUNC_QUERY, 48'h0000_0000_0FFF);
        push_req(FUNC_QUERY, 48'h0000_00FF_F123);
        push_req(FUNC_QUERY, 48'h0000_0100_0000);
        push_req(FUNC_QUERY, 48'h0000_000F_F000);
        push_req(FUNC_QUERY, 48'hFFFF_FFFF_E000);
        push_req(FUNC_QUERY, 48'h0000_0000_2000);
        drain();

        // Count above the region limit saturates.
        set_regions(2'd3, 36'($urandom), 13'd40, {4'($urandom), 32'($urandom)}, 13'd30);
        run_random(320, 1'b1, 1'b1);

        // One region, and it has no pages; then no regions at all.
        set_regions(2'd1, 36'($urandom), 13'd0, 36'($urandom), 13'd50);
        run_random(40, 1'b0, 1'b0);
        write_reg(CFG_REGION_COUNT, FrameW'(2'd0));
        run_random(30, 1'b1, 1'b0);

        // Overlapping regions: region 1 covers part of region 0.
        set_regions(2'd2, 36'h1000, 13'd1000, 36'h1100, 13'd5000);
        run_random(380, 1'b1, 1'b1);

        // Frames wrap past the top of the 36-bit range.
        set_regions(2'd2, 36'hF_FFFF_FFFF, 13'd0, 36'hF_FFFF_FFF0, 13'd4096);
        run_random(300, 1'b1, 1'b0);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/pfba_pkg.sv
hdl/pfba_bitmap_ram.sv
hdl/pfba_stack_ram.sv
hdl/page_frame_bitmap_allocator.sv
dv/page_frame_bitmap_allocator_test.sv
